// File: hw/rtl/gbse_pkg.sv
// Shared types and constants of the gray / blur / Sobel edge pipeline.
// Used by the front end, the queue, the filter back end and the top level.
package gbse_pkg;

    // Frame geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int RESET_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W       = 16;
    localparam int ROW_W       = HGT_W + 1;
    localparam int TOT_W       = WID_W + HGT_W;
    localparam int POS_W       = WID_W + ROW_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Reciprocal constants for the truncating divides by 3 and by 9
    localparam logic [19:0] RECIP3 = 20'd683;
    localparam logic [24:0] RECIP9 = 25'd7282;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_THRESH = 2'd2;

    // Classified item handed from front to back
    typedef struct packed {
        logic [7:0]       gray;
        logic [COL_W-1:0] col;
        logic             blur_int;
        logic             out_vld;
        logic             out_int;
        logic             out_last;
    } t_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Geometry recalculation sequencer
    typedef enum logic [2:0] {
        CAL_IDLE = 3'b001,
        CAL_MUL  = 3'b010,
        CAL_SUM  = 3'b100
    } t_cal_state;

endpackage

// File: hw/rtl/gray_blur_sobel_edge_pipeline.sv
// Top level of the gray / box blur / Sobel edge pipeline.
// Depends on gbse_pkg, gbse_front, gbse_fifo and gbse_back.
//
// Takes one RGB pixel or flush item per clock and gives at most one output pixel
// per item, so the sustained rate is one item per cycle while the receiver keeps
// up; the line buffers in the back end, each read at one column and written at
// one column per item, set it. The result for pixel p of a frame leaves with item
// p + 2*width + 2, so flush items (tuser = 1) drain the final results; a flush
// before the last pixel is taken and dropped. An accepted item passes the queue
// and stages a, w, s, bl, x, y and z to its result register. After reset and
// after a width or height write, input is held off while the position and frame
// size are recomputed. The line buffers need no clearing pass after reset.
module gray_blur_sobel_edge_pipeline
    import gbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tuser,   // mode [0]: 0 pixel, 1 flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_value [7:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_entry     push_entry;
    t_entry     head_entry;
    t_q_stat    q_stat;
    logic       push;
    logic       pop;
    logic [7:0] thresh;

    // Accept and classify items
    gbse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_rgb       (s_axis_tdata),
        .i_stat      (q_stat),
        .o_push      (push),
        .o_entry     (push_entry),
        .o_thresh    (thresh)
    );

    // Queue between the two halves
    gbse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    // Filter and deliver results
    gbse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_stat   (q_stat),
        .o_pop    (pop),
        .i_thresh (thresh),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

// File: hw/rtl/gbse_fifo.sv
// Short register queue that decouples the front end from the filter back end.
// Depends on gbse_pkg for the item type and depth.
module gbse_fifo
    import gbse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_entry,
    output t_q_stat o_stat
);

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_count;

    assign o_entry      = r_mem[r_rd];
    assign o_stat.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");

endmodule

// File: hw/rtl/gbse_front.sv
// Front end: configuration registers, frame position bookkeeping, gray conversion
// and classification of each item. Depends on gbse_pkg.
module gbse_front
    import gbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [23:0] i_rgb,
    input  t_q_stat     i_stat,
    output logic        o_push,
    output t_entry      o_entry,
    output logic [7:0]  o_thresh
);

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [7:0]       r_thresh;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [POS_W-1:0] r_q;
    logic [TOT_W-1:0] r_total;
    logic [POS_W-1:0] r_last_q;
    t_cal_state       r_cal_state;

    logic [POS_W-1:0] lag;
    logic             in_frame;
    logic             wide;
    logic             accept;
    logic             advance;
    logic             frame_end;
    logic [9:0]       rgb_sum;
    logic [19:0]      gray_prod;
    logic [31:0]      c32;
    logic [31:0]      r32;
    logic [31:0]      h32;
    logic [31:0]      wv32;

    assign o_cfg_ready = 1'b1;
    assign o_thresh    = r_thresh;
    assign o_ready     = (r_cal_state == CAL_IDLE) && !i_stat.full;

    // Classify the item at the current position
    always_comb begin
        lag       = POS_W'({r_width, 1'b0}) + POS_W'(2);
        in_frame  = r_q < POS_W'(r_total);
        wide      = r_width >= WID_W'(3);
        c32       = 32'(r_col);
        r32       = 32'(r_row);
        h32       = 32'(r_height);
        wv32      = 32'(i_cfg_data[10:0]);
        accept    = i_valid && o_ready;
        advance   = accept && !(i_mode && in_frame);
        frame_end = (r_q >= lag) && (r_q >= r_last_q);
        rgb_sum   = 10'(i_rgb[7:0]) + 10'(i_rgb[15:8]) + 10'(i_rgb[23:16]);
        gray_prod = 20'(rgb_sum) * RECIP3;

        o_push            = advance;
        o_entry.gray      = gray_prod[18:11];
        o_entry.col       = r_col;
        o_entry.blur_int  = wide && (c32 >= 32'd2) && (r32 >= 32'd2) && (r32 < h32);
        o_entry.out_int   = wide && (((c32 >= 32'd3) && (r32 >= 32'd3) && (r32 <= h32)) ||
                            ((c32 == 32'd0) && (r32 >= 32'd4) && (r32 <= h32 + 32'd1)));
        o_entry.out_vld   = (r_q >= lag) && (r_q <= r_last_q);
        o_entry.out_last  = (r_q == r_last_q);
    end

    // Configuration writes and geometry recalculation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WID_W'(RESET_WIDTH);
            r_height    <= HGT_W'(768);
            r_thresh    <= 8'd50;
            r_cal_state <= CAL_MUL;
        end else begin
            unique case (r_cal_state)
                CAL_MUL:  r_cal_state <= CAL_SUM;
                CAL_SUM:  r_cal_state <= CAL_IDLE;
                CAL_IDLE: r_cal_state <= CAL_IDLE;
                default:  r_cal_state <= CAL_MUL;
            endcase
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH: begin
                        if (wv32 == 32'd0) begin
                            r_width <= WID_W'(1);
                        end else if (wv32 > 32'(MAX_WIDTH)) begin
                            r_width <= WID_W'(MAX_WIDTH);
                        end else begin
                            r_width <= WID_W'(wv32);
                        end
                        r_cal_state <= CAL_MUL;
                    end
                    CFG_HEIGHT: begin
                        r_height    <= (i_cfg_data == '0) ? HGT_W'(1) : i_cfg_data;
                        r_cal_state <= CAL_MUL;
                    end
                    CFG_THRESH: r_thresh <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Derived geometry: frame size, position of the final result
    always_ff @(posedge i_clk) begin
        if (r_cal_state == CAL_MUL) begin
            r_total <= TOT_W'(r_width) * TOT_W'(r_height);
        end
        if (r_cal_state == CAL_SUM) begin
            r_last_q <= POS_W'(r_total) + POS_W'({r_width, 1'b0}) + POS_W'(1);
        end
    end

    // Advance the position counters, zero after the final result; r_q recomputed in CAL_MUL
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_q   <= '0;
        end else if (r_cal_state == CAL_MUL) begin
            r_q <= POS_W'(r_row) * POS_W'(r_width) + POS_W'(r_col);
        end else if (advance) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
                r_q   <= '0;
            end else begin
                if (32'(r_col) + 32'd1 >= 32'(r_width)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                r_q <= r_q + 1'b1;
            end
        end
    end

    a_no_push_in_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_cal_state == CAL_IDLE))
        else $error("item pushed during geometry recalculation");
    a_last_is_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.out_last) |-> o_entry.out_vld)
        else $error("frame end marked on an item without result");

endmodule

// File: hw/rtl/gbse_back.sv
// Back end: gray line buffer and 3x3 box blur, blur line buffer and Sobel test,
// output register. Depends on gbse_pkg.
module gbse_back
    import gbse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  t_q_stat    i_stat,
    output logic       o_pop,
    input  logic [7:0] i_thresh,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_value,
    output logic       o_last
);

    logic [15:0] r_gmem [MAX_WIDTH];
    logic [15:0] r_bmem [MAX_WIDTH];

    t_entry r_a, r_w, r_s, r_bl, r_x, r_y, r_z;
    logic   r_a_vld, r_w_vld, r_s_vld, r_bl_vld, r_x_vld, r_y_vld, r_z_vld;

    logic [15:0] r_grd;
    logic [15:0] r_brd;
    logic [7:0]  r_gwin [3][3];
    logic [7:0]  r_bwin [3][3];
    logic [11:0] r_sum;
    logic [7:0]  r_ctr;
    logic [7:0]  r_bl_val;
    logic signed [11:0] r_dx;
    logic signed [11:0] r_dy;
    logic [7:0]  r_yc;
    logic [19:0] r_dx2;
    logic [19:0] r_dy2;
    logic [7:0]  r_zc;
    logic [19:0] r_thr_sq;
    logic        r_out_vld;
    logic [7:0]  r_out_val;
    logic        r_out_last;

    logic        adv;
    logic [11:0] sum;
    logic [24:0] blur_prod;
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic [9:0]  adx;
    logic [9:0]  ady;
    logic [20:0] mag;

    assign adv     = !(r_out_vld && !i_ready);
    assign o_pop   = adv && !i_stat.empty;
    assign o_valid = r_out_vld;
    assign o_value = r_out_val;
    assign o_last  = r_out_last;

    // Window arithmetic
    always_comb begin
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum = sum + 12'(r_gwin[i][j]);
            end
        end
        blur_prod = 25'(r_sum) * RECIP9;
        // row 2 is north, row 0 south; offset 0 east, offset 2 west
        dx = (12'(r_bwin[2][0]) - 12'(r_bwin[2][2]))
           + 12'({r_bwin[1][0], 1'b0}) - 12'({r_bwin[1][2], 1'b0})
           + (12'(r_bwin[0][0]) - 12'(r_bwin[0][2]));
        dy = (12'(r_bwin[0][0]) + 12'({r_bwin[0][1], 1'b0}) + 12'(r_bwin[0][2]))
           - (12'(r_bwin[2][0]) + 12'({r_bwin[2][1], 1'b0}) + 12'(r_bwin[2][2]));
        adx = r_dx[11] ? 10'(-r_dx) : 10'(r_dx);
        ady = r_dy[11] ? 10'(-r_dy) : 10'(r_dy);
        mag = 21'(r_dx2) + 21'(r_dy2);
    end

    // Threshold squared, times sixteen
    always_ff @(posedge i_clk) begin
        r_thr_sq <= {16'(i_thresh) * 16'(i_thresh), 4'b0000};
    end

    // Gray line buffer: word holds the two previous rows at this column
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_a_vld) begin
                r_gmem[r_a.col] <= {r_grd[7:0], r_a.gray};
            end
            if (r_a_vld && (r_a.col == i_entry.col)) begin
                r_grd <= {r_grd[7:0], r_a.gray};
            end else begin
                r_grd <= r_gmem[i_entry.col];
            end
        end
    end

    // Blur line buffer, same arrangement
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_bl_vld) begin
                r_bmem[r_bl.col] <= {r_brd[7:0], r_bl_val};
            end
            if (r_bl_vld && (r_bl.col == r_s.col)) begin
                r_brd <= {r_brd[7:0], r_bl_val};
            end else begin
                r_brd <= r_bmem[r_s.col];
            end
        end
    end

    // Payload of the filter stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a  <= i_entry;
            r_w  <= r_a;
            r_s  <= r_w;
            r_bl <= r_s;
            r_x  <= r_bl;
            r_y  <= r_x;
            r_z  <= r_y;
            if (r_a_vld) begin
                for (int i = 0; i < 3; i++) begin
                    r_gwin[i][2] <= r_gwin[i][1];
                    r_gwin[i][1] <= r_gwin[i][0];
                end
                r_gwin[0][0] <= r_a.gray;
                r_gwin[1][0] <= r_grd[7:0];
                r_gwin[2][0] <= r_grd[15:8];
            end
            r_sum    <= sum;
            r_ctr    <= r_gwin[1][1];
            r_bl_val <= r_s.blur_int ? blur_prod[23:16] : r_ctr;
            if (r_bl_vld) begin
                for (int i = 0; i < 3; i++) begin
                    r_bwin[i][2] <= r_bwin[i][1];
                    r_bwin[i][1] <= r_bwin[i][0];
                end
                r_bwin[0][0] <= r_bl_val;
                r_bwin[1][0] <= r_brd[7:0];
                r_bwin[2][0] <= r_brd[15:8];
            end
            r_dx  <= dx;
            r_dy  <= dy;
            r_yc  <= r_bwin[1][1];
            r_dx2 <= 20'(adx) * 20'(adx);
            r_dy2 <= 20'(ady) * 20'(ady);
            r_zc  <= r_yc;
            if (r_z.out_int) begin
                r_out_val <= (mag > 21'(r_thr_sq)) ? 8'd255 : 8'd0;
            end else begin
                r_out_val <= r_zc;
            end
            r_out_last <= r_z.out_last;
        end
    end

    // Stage valid bits; hold everything while the result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_w_vld   <= 1'b0;
            r_s_vld   <= 1'b0;
            r_bl_vld  <= 1'b0;
            r_x_vld   <= 1'b0;
            r_y_vld   <= 1'b0;
            r_z_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= o_pop;
            r_w_vld   <= r_a_vld;
            r_s_vld   <= r_w_vld;
            r_bl_vld  <= r_s_vld;
            r_x_vld   <= r_bl_vld;
            r_y_vld   <= r_x_vld;
            r_z_vld   <= r_y_vld;
            r_out_vld <= r_z_vld && r_z.out_vld;
        end
    end

endmodule

// File: verif/tb_gray_blur_sobel_edge_pipeline.sv
// Testbench for the gray / box blur / Sobel edge pipeline: random frames of many sizes.
// Needs gbse_pkg and the gray_blur_sobel_edge_pipeline RTL only.
`timescale 1ns / 1ps

// Frame predictor and store of expected output pixels
class edge_frame_board;
    localparam int unsigned RING = 2 * gbse_pkg::MAX_WIDTH + 3;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_pixel_out;

    logic [7:0]  gray_ring [RING];
    logic [7:0]  blur_ring [RING];
    int unsigned wid, hgt, thresh;
    int unsigned row, col, slot;
    t_pixel_out  pending [$];
    int          errors;

    function new();
        wid = 1024; hgt = 768; thresh = 50;
        row = 0; col = 0; slot = 0; errors = 0;
        foreach (gray_ring[i]) begin
            gray_ring[i] = '0;
            blur_ring[i] = '0;
        end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
        int unsigned v;
        case (idx)
            gbse_pkg::CFG_WIDTH: begin
                v = 32'(data & 16'h07FF);
                if (v == 0) v = 1;
                if (v > gbse_pkg::MAX_WIDTH) v = gbse_pkg::MAX_WIDTH;
                wid = v;
            end
            gbse_pkg::CFG_HEIGHT: hgt = (data == 0) ? 1 : 32'(data);
            gbse_pkg::CFG_THRESH: thresh = 32'(data & 16'h00FF);
            default: ;
        endcase
    endfunction

    function int unsigned back_slot(int unsigned back);
        return (slot + 2 * RING - (back % (2 * RING))) % RING;
    endfunction

    function bit interior(int unsigned p);
        int unsigned r, c;
        r = p / wid;
        c = p % wid;
        return r >= 1 && r + 1 < hgt && c >= 1 && c + 1 < wid;
    endfunction

    // Advance the predicted pipeline by one accepted item
    function void note_input(bit flush, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        int unsigned total, lag, q, bp, sp, sum, val;
        int nw, nn, ne, ww, ee, sw, ss, se, dx, dy;
        t_pixel_out o;
        total = wid * hgt;
        lag   = 2 * wid + 2;
        q     = row * wid + col;
        if (q < total) begin
            if (flush) return;
            gray_ring[slot] = 8'((int'(red) + int'(green) + int'(blue)) / 3);
        end
        // blur the position one row and one pixel behind
        if (q >= wid + 1 && q - (wid + 1) < total) begin
            bp = q - (wid + 1);
            if (interior(bp)) begin
                sum = 0;
                for (int dr = 0; dr < 3; dr++)
                    for (int dc = 0; dc < 3; dc++)
                        sum += gray_ring[back_slot(dr * wid + dc)];
                blur_ring[back_slot(wid + 1)] = 8'(sum / 9);
            end else begin
                blur_ring[back_slot(wid + 1)] = gray_ring[back_slot(wid + 1)];
            end
        end
        // edge test for the position two rows and two pixels behind
        if (q >= lag && q - lag < total) begin
            sp = q - lag;
            if (interior(sp)) begin
                nw = int'(blur_ring[back_slot(lag + wid + 1)]);
                nn = int'(blur_ring[back_slot(lag + wid)]);
                ne = int'(blur_ring[back_slot(lag + wid - 1)]);
                ww = int'(blur_ring[back_slot(lag + 1)]);
                ee = int'(blur_ring[back_slot(lag - 1)]);
                sw = int'(blur_ring[back_slot(lag - wid + 1)]);
                ss = int'(blur_ring[back_slot(lag - wid)]);
                se = int'(blur_ring[back_slot(lag - wid - 1)]);
                dx = -nw + ne - 2 * ww + 2 * ee - sw + se;
                dy = se + 2 * ss + sw - ne - 2 * nn - nw;
                val = (dx * dx + dy * dy > 16 * int'(thresh) * int'(thresh)) ? 255 : 0;
            end else begin
                val = 32'(blur_ring[back_slot(lag)]);
            end
            o.value = val[7:0];
            o.last  = (sp == total - 1);
            pending.push_back(o);
        end
        if (q >= lag && q - lag >= total - 1) begin
            row = 0; col = 0; slot = 0;
        end else begin
            col++;
            if (col >= wid) begin
                col = 0;
                row++;
            end
            slot = (slot + 1) % RING;
        end
    endfunction

    // Compare one output pixel with the oldest prediction
    function void check_output(logic [7:0] value, logic last);
        t_pixel_out e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual value %0d last %0b",
                     $time, value, last);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (value !== e.value) begin
            $display("%0t: value mismatch, expected %0d, actual %0d", $time, e.value, value);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module tb_gray_blur_sobel_edge_pipeline;
    import gbse_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    edge_frame_board board = new();
    bit calm = 1'b0;        // no idling on either side
    bit hold_req = 1'b0;    // ask the receiver for a long hold-off
    int idle_count = 0;

    gray_blur_sobel_edge_pipeline u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Note every handshake on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.set_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                board.note_input(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tdata[23:16]);
            if (m_axis_tvalid && m_axis_tready) board.check_output(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (idle_count >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, with one long hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    task automatic send_item(bit flush, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        while (!calm && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= flush;
        s_axis_tdata  <= {blue, green, red};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_pixel();
        send_item(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // Let every predicted pixel out, then the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One whole frame of random pixels, then enough trailing items to empty it
    task automatic run_frame(logic [15:0] w, logic [15:0] h, logic [15:0] th);
        int unsigned npix, ntail;
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_THRESH, th);
        npix  = board.wid * board.hgt;
        ntail = 2 * board.wid + 2;
        for (int unsigned i = 0; i < npix; i++) begin
            // a flush inside the frame is dropped without advancing
            if ($urandom_range(99) < 3) send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            send_random_pixel();
        end
        // surplus pixels act as flushes
        for (int unsigned i = 0; i < ntail; i++) begin
            if ($urandom_range(3) == 0) send_random_pixel();
            else send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int unsigned sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flush with nothing in the frame: dropped
        send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
        // extreme colours in a small interior frame, threshold zero
        drain();
        write_reg(CFG_WIDTH, 16'd4);
        write_reg(CFG_HEIGHT, 16'd4);
        write_reg(CFG_THRESH, 16'd0);
        for (int i = 0; i < 16; i++) begin
            if (i % 3 == 0) send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
            else if (i % 3 == 1) send_item(1'b0, 8'h00, 8'h00, 8'h00);
            else send_item(1'b0, 8'hFF, 8'h00, 8'h80);
        end
        for (int i = 0; i < 10; i++) send_item(1'b1, '0, '0, '0);

        // height at its top, then zero width and height (taken as one)
        drain();
        write_reg(CFG_HEIGHT, 16'hFFFF);
        run_frame(16'd0, 16'd0, 16'd255);
        // long receiver hold-off while the sender keeps offering a frame
        drain();
        hold_req = 1'b1;
        run_frame(16'd12, 16'd8, 16'd20);
        // a calm stretch
        calm = 1'b1;
        run_frame(16'd9, 16'd6, 16'd5);
        calm = 1'b0;

        // random small frames
        sent = 0;
        while (sent < 800) begin
            logic [15:0] w, h, th;
            w  = 16'($urandom_range(1, 14));
            h  = 16'($urandom_range(1, 9));
            th = ($urandom_range(9) == 0) ? 16'($urandom_range(255)) : 16'($urandom_range(30));
            run_frame(w, h, th);
            sent += 32'(w) * 32'(h) + 2 * 32'(w) + 2;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
